// ===== src/tst_pkg.sv =====
// Package with the types, constants and state codes of the trapezoid step timer.
package tst_pkg;

  localparam int unsigned CountWidth = 24;

  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
  localparam logic [19:0] UsPerS = 20'd1000000;

  localparam logic [1:0] RegMaxVelocity = 2'd0;
  localparam logic [1:0] RegAcceleration = 2'd1;
  localparam logic [1:0] RegRadPerStep = 2'd2;

  localparam logic [31:0] ResetMaxVelocity = 32'd655360;
  localparam logic [31:0] ResetAcceleration = 32'd655360;
  localparam logic [31:0] ResetRadPerStep = 32'd134929285;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [CountWidth-1:0] delta_steps;
  } tst_in_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic signed [31:0] position;
    logic [31:0]        next_step_us;
    logic               done_res;
  } tst_out_t;

  typedef enum logic [5:0] {
    StIdle,
    StMulDist,
    StDist,
    StMulDa,
    StMulVv,
    StShort,
    StSqrtPeak,
    StPeakSet,
    StMulPp,
    StDivAe,
    StAeSet,
    StDivT1,
    StT1Set,
    StDivT2,
    StMtSet,
    StStepBegin,
    StMulTh,
    StThSet,
    StRootBegin,
    StDivRoot,
    StRootMul,
    StRootFrac,
    StRootSum,
    StSqrtRoot,
    StRootDone,
    StCruise1,
    StCruise1Set,
    StCruise2,
    StCruiseSet,
    StDivWait,
    StSqrtWait,
    StMulWait,
    StOut
  } tst_state_e;

endpackage

// ===== src/trapezoid_step_timer.sv =====
// Top level of the trapezoid step timer: move setup and per-step time sequencer.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  tst_in_t
//   out      output     out_valid/out_stall tst_out_t
//   cfg      input      cfg_valid/cfg_ready index and 32-bit data
//
// The longest item is a short-move start with two square roots and five divisions. Divisions
// run on the shared 64-bit restoring divider, square roots on the shared square-root unit,
// and products on the shared 32x32 multiplier.
// Reset clears the position, move state and registers to their defaults.
// The block takes no item while one is at work; a finished result waits in the output
// register, and the next item is taken meanwhile and holds before its own result.
module trapezoid_step_timer
  import tst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tst_in_t                in_data_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tst_out_t               out_data_o,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int unsigned CW = CountWidth;

  tst_state_e state_q, state_d;

  logic [31:0] max_vel_q, accel_q, rps_q;
  logic [31:0] pos_q, pos_d;
  logic [CW-1:0] taken_q, taken_d, total_q, total_d;
  logic dir_q, dir_d;
  logic [31:0] dist_q, dist_d, peak_q, peak_d, ae_q, ae_d, ds_q, ds_d, mt_q, mt_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [31:0] th_q, th_d, t1_q, t1_d;
  logic [2:0]  phase_q, phase_d;
  logic pulse_q, pulse_d, done_q, done_d;
  tst_out_t out_q;
  logic out_valid_q;
  logic load_out;

  // Shared multiplier: one 32 x 32 product a cycle.
  logic [31:0] mul_x_q, mul_x_d, mul_y_q, mul_y_d;
  logic [63:0] mul_p;
  assign mul_p = {32'd0, mul_x_q} * {32'd0, mul_y_q};

  // Shared divider: 64 / 64, restoring, one bit a cycle.
  logic        div_go;
  logic [63:0] div_n_in, div_d_in;
  logic [63:0] dq_q, dr_q, dd_q;
  logic [6:0]  dcnt_q;
  logic        dbusy_q;
  logic [64:0] dtrial;
  logic [63:0] drem_sh;
  assign drem_sh = {dr_q[62:0], dq_q[63]};
  assign dtrial = {1'b0, drem_sh} - {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (div_go) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 7'd64;
    end else if (dbusy_q) begin
      dcnt_q  <= dcnt_q - 7'd1;
      dbusy_q <= (dcnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      dq_q <= div_n_in;
      dr_q <= '0;
      dd_q <= div_d_in;
    end else if (dbusy_q) begin
      if (!dr_q[63] && !dtrial[64]) begin
        dr_q <= dtrial[63:0];
        dq_q <= {dq_q[62:0], 1'b1};
      end else begin
        dr_q <= drem_sh;
        dq_q <= {dq_q[62:0], 1'b0};
      end
    end
  end

  // Shared square root: 64-bit radicand, one result bit a cycle.
  logic        sq_go;
  logic [63:0] sq_in;
  logic [63:0] sx_q, sres_q, sbit_q;
  logic        sbusy_q;
  logic [63:0] ssum;
  assign ssum = sres_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (sq_go) begin
      sbusy_q <= 1'b1;
    end else if (sbusy_q && sbit_q[1:0] != 2'b00) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_go) begin
      sx_q   <= sq_in;
      sres_q <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
    end else if (sbusy_q) begin
      if (sx_q >= ssum) begin
        sx_q   <= sx_q - ssum;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q <= ResetMaxVelocity;
      accel_q   <= ResetAcceleration;
      rps_q     <= ResetRadPerStep;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        RegMaxVelocity:  max_vel_q <= cfg_data_i;
        RegAcceleration: accel_q   <= cfg_data_i;
        RegRadPerStep:   rps_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall = (state_q != StIdle);

  function automatic logic [31:0] sat64(input logic [63:0] x);
    sat64 = (x[63:32] != 32'd0) ? Sat32 : x[31:0];
  endfunction

  logic [CW-1:0] raw_cnt, mag_cnt;
  assign raw_cnt = in_data_i.delta_steps[CW-1:0];
  assign mag_cnt = raw_cnt[CW-1] ? (~raw_cnt + 1'b1) : raw_cnt;
  logic [CW:0] knext;
  assign knext = {1'b0, taken_q} + (CW+1)'(2);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    taken_d = taken_q;
    total_d = total_q;
    dir_d   = dir_q;
    dist_d  = dist_q;
    peak_d  = peak_q;
    ae_d    = ae_q;
    ds_d    = ds_q;
    mt_d    = mt_q;
    a_d     = a_q;
    b_d     = b_q;
    th_d    = th_q;
    t1_d    = t1_q;
    phase_d = phase_q;
    pulse_d = pulse_q;
    done_d  = done_q;
    mul_x_d = mul_x_q;
    mul_y_d = mul_y_q;
    div_go  = 1'b0;
    div_n_in = a_q;
    div_d_in = b_q;
    sq_go   = 1'b0;
    sq_in   = a_q;
    load_out = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid && !in_stall) begin
          pulse_d = 1'b0;
          done_d  = 1'b0;
          t1_d    = '0;
          if (in_data_i.cmd == CmdStart) begin
            if (raw_cnt != '0) dir_d = ~raw_cnt[CW-1];
            total_d = mag_cnt;
            taken_d = '0;
            mul_x_d = rps_q;
            mul_y_d = 32'(mag_cnt);
            state_d = StMulDist;
          end else if (taken_q >= total_q) begin
            done_d  = 1'b1;
            state_d = StOut;
          end else begin
            pulse_d = 1'b1;
            pos_d   = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
            taken_d = taken_q + 1'b1;
            if (taken_q + 1'b1 == total_q) begin
              done_d  = 1'b1;
              state_d = StOut;
            end else begin
              mul_x_d = rps_q;
              mul_y_d = 32'(knext[CW-1:0]) + ((knext[CW]) ? 32'(1) << CW : 32'd0);
              state_d = StMulTh;
            end
          end
        end
      end
      StMulDist: begin
        dist_d  = sat64(mul_p >> 16);
        state_d = StDist;
      end
      StDist: begin
        mul_x_d = dist_q;
        mul_y_d = accel_q;
        state_d = StMulDa;
      end
      StMulDa: begin
        a_d     = mul_p;
        mul_x_d = max_vel_q;
        mul_y_d = max_vel_q;
        state_d = StMulVv;
      end
      StMulVv: begin
        b_d     = mul_p;
        state_d = StShort;
      end
      StShort: begin
        if (a_q < b_q) begin
          sq_go   = 1'b1;
          sq_in   = a_q;
          state_d = StSqrtPeak;
        end else begin
          peak_d  = max_vel_q;
          state_d = StPeakSet;
        end
      end
      StSqrtPeak: begin
        if (!sbusy_q) begin
          peak_d  = sres_q[31:0];
          state_d = StPeakSet;
        end
      end
      StPeakSet: begin
        mul_x_d = peak_q;
        mul_y_d = peak_q;
        state_d = StMulPp;
      end
      StMulPp: begin
        if (accel_q == 32'd0) begin
          ae_d    = Sat32;
          state_d = StAeSet;
        end else begin
          div_go   = 1'b1;
          div_n_in = mul_p;
          div_d_in = {31'd0, accel_q, 1'b0};
          state_d  = StDivAe;
        end
      end
      StDivAe: begin
        if (!dbusy_q && !div_go) begin
          ae_d    = sat64(dq_q);
          state_d = StAeSet;
        end
      end
      StAeSet: begin
        ds_d = (dist_q > ae_q) ? dist_q - ae_q : 32'd0;
        if (peak_q == 32'd0) begin
          t1_d    = Sat32;
          state_d = StT1Set;
        end else begin
          div_go   = 1'b1;
          div_n_in = {32'd0, dist_q} * 64'(UsPerS);
          div_d_in = {32'd0, peak_q};
          state_d  = StDivT1;
        end
      end
      StDivT1: begin
        if (!dbusy_q) begin
          t1_d    = sat64(dq_q);
          state_d = StT1Set;
        end
      end
      StT1Set: begin
        if (accel_q == 32'd0) begin
          mt_d    = Sat32;
          state_d = StMtSet;
        end else begin
          div_go   = 1'b1;
          div_n_in = {32'd0, peak_q} * 64'(UsPerS);
          div_d_in = {32'd0, accel_q};
          state_d  = StDivT2;
        end
      end
      StDivT2: begin
        if (!dbusy_q) begin
          mt_d    = sat64({32'd0, t1_q} + {32'd0, sat64(dq_q)});
          state_d = StMtSet;
        end
      end
      StMtSet: begin
        if (total_q == '0) begin
          done_d  = 1'b1;
          t1_d    = '0;
          state_d = StOut;
        end else begin
          mul_x_d = rps_q;
          mul_y_d = 32'd1;
          state_d = StMulTh;
        end
      end
      StMulTh: begin
        th_d    = sat64(mul_p >> 16);
        state_d = StThSet;
      end
      StThSet: begin
        if (th_q < ae_q) begin
          a_d     = {32'd0, th_q};
          phase_d = 3'd0;
          state_d = StRootBegin;
        end else if (th_q < ds_q) begin
          state_d = StCruise1;
        end else begin
          a_d     = {32'd0, (th_q >= dist_q) ? 32'd0 : dist_q - th_q};
          phase_d = 3'd1;
          state_d = StRootBegin;
        end
      end
      StRootBegin: begin
        if (accel_q == 32'd0) begin
          b_d     = {32'd0, Sat32};
          state_d = StRootDone;
        end else begin
          div_go   = 1'b1;
          div_n_in = a_q * 64'd2000000;
          div_d_in = {32'd0, accel_q};
          state_d  = StDivRoot;
        end
      end
      StDivRoot: begin
        if (!dbusy_q) begin
          a_d     = dq_q;
          b_d     = dr_q;
          state_d = StRootMul;
        end
      end
      StRootMul: begin
        if (a_q > 64'd18446744073708) begin
          b_d     = {32'd0, Sat32};
          state_d = StRootDone;
        end else begin
          a_d      = a_q * 64'(UsPerS);
          div_go   = 1'b1;
          div_n_in = b_q * 64'(UsPerS);
          div_d_in = {32'd0, accel_q};
          state_d  = StRootFrac;
        end
      end
      StRootFrac: begin
        if (!dbusy_q) begin
          sq_go   = 1'b1;
          sq_in   = a_q + dq_q;
          state_d = StSqrtRoot;
        end
      end
      StSqrtRoot: begin
        if (!sbusy_q) begin
          b_d     = {32'd0, sres_q[31:0]};
          state_d = StRootDone;
        end
      end
      StRootDone: begin
        if (phase_q == 3'd0) t1_d = b_q[31:0];
        else t1_d = (mt_q > b_q[31:0]) ? mt_q - b_q[31:0] : 32'd0;
        state_d = StOut;
      end
      StCruise1: begin
        if (peak_q == 32'd0) begin
          a_d     = {32'd0, Sat32};
          state_d = StCruise1Set;
        end else begin
          div_go   = 1'b1;
          div_n_in = {32'd0, th_q} * 64'(UsPerS);
          div_d_in = {32'd0, peak_q};
          state_d  = StDivWait;
        end
      end
      StDivWait: begin
        if (!dbusy_q) begin
          a_d     = {32'd0, sat64(dq_q)};
          state_d = StCruise1Set;
        end
      end
      StCruise1Set: begin
        div_go   = 1'b1;
        div_n_in = {32'd0, peak_q} * 64'(UsPerS);
        div_d_in = {31'd0, accel_q, 1'b0};
        state_d  = StCruise2;
      end
      StCruise2: begin
        if (!dbusy_q) begin
          t1_d    = sat64(a_q + {32'd0, (accel_q == 32'd0) ? Sat32 : sat64(dq_q)});
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || !out_stall) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      taken_q <= '0;
      total_q <= '0;
      dir_q   <= 1'b1;
      dist_q  <= '0;
      peak_q  <= '0;
      ae_q    <= '0;
      ds_q    <= '0;
      mt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      taken_q <= taken_d;
      total_q <= total_d;
      dir_q   <= dir_d;
      dist_q  <= dist_d;
      peak_q  <= peak_d;
      ae_q    <= ae_d;
      ds_q    <= ds_d;
      mt_q    <= mt_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    th_q    <= th_d;
    t1_q    <= t1_d;
    phase_q <= phase_d;
    pulse_q <= pulse_d;
    done_q  <= done_d;
    mul_x_q <= mul_x_d;
    mul_y_q <= mul_y_d;
    if (load_out) begin
      out_q.step_pulse   <= pulse_q;
      out_q.direction    <= dir_q;
      out_q.position     <= pos_q;
      out_q.next_step_us <= done_q ? 32'd0 : t1_q;
      out_q.done_res     <= done_q;
    end
  end

  assign out_valid  = out_valid_q;
  assign out_data_o = out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall)
    else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  a_taken_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (taken_q <= total_q))
    else $error("step count overran the move");

endmodule
